FILE: sv/tls_record_deframer_defines.svh
// Assertion macros used by the TLS record deframer top level.
`ifndef TLS_RECORD_DEFRAMER_DEFINES_SVH
`define TLS_RECORD_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define TLSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tlsd assertion failed");
`define TLSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tlsd assertion failed");
`else
`define TLSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TLSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/tlsd_pkg.sv
// Types and constants shared by the TLS record deframer modules.
`default_nettype none
package tlsd_pkg;

	// Parser phases; also the byte_part code of a byte.
	localparam logic [2:0] PH_HDR = 3'd0;
	localparam logic [2:0] PH_PAY = 3'd1;
	localparam logic [2:0] PH_HSH = 3'd2;
	localparam logic [2:0] PH_HSB = 3'd3;
	localparam logic [2:0] PH_ERR = 3'd4;

	// Status codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_VERSION = 3'd1;
	localparam logic [2:0] ST_BAD_TYPE    = 3'd2;
	localparam logic [2:0] ST_TOO_LONG    = 3'd3;
	localparam logic [2:0] ST_HS_OVERRUN  = 3'd4;

	// Record content types.
	localparam logic [7:0] CT_CCS       = 8'd20;
	localparam logic [7:0] CT_ALERT     = 8'd21;
	localparam logic [7:0] CT_HANDSHAKE = 8'd22;
	localparam logic [7:0] CT_APP_DATA  = 8'd23;

	localparam int unsigned MAX_LEN_W     = 15;
	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 15'd16384;
	// Padding allowance (256) plus MAC allowance (16) for non-application records.
	localparam logic [16:0] LEN_ALLOWANCE = 17'd272;
	localparam logic [7:0] MIN_MAJOR      = 8'd3;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  byte_part;
		logic [7:0]  content_type;
		logic [7:0]  version_major;
		logic [7:0]  version_minor;
		logic [15:0] record_length;
		logic [7:0]  handshake_type;
		logic [23:0] handshake_length;
		logic        header_done;
		logic        record_last;
		logic        handshake_last;
		logic [2:0]  status;
	} result_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} q_status_t;

endpackage
`default_nettype wire

FILE: sv/tlsd_parser.sv
// Front end: record and handshake header parser, one byte per cycle while bytes are accepted.
`default_nettype none
module tlsd_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           fire,
	input  wire logic [7:0]                     data_byte,
	input  wire logic [tlsd_pkg::MAX_LEN_W-1:0] max_len,
	output tlsd_pkg::result_t                   result
);
	import tlsd_pkg::*;

	logic [2:0]  phase_q, phase_d;
	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  major_q, major_d;
	logic [7:0]  minor_q, minor_d;
	logic [15:0] length_q, length_d;
	logic [15:0] rec_rem_q, rec_rem_d;
	logic [1:0]  hs_cnt_q, hs_cnt_d;
	logic [7:0]  hs_type_q, hs_type_d;
	logic [23:0] hs_len_q, hs_len_d;
	logic [23:0] hs_rem_q, hs_rem_d;
	logic [2:0]  err_q, err_d;

	logic [15:0] rec_dec;
	logic [23:0] hs_dec;
	logic [16:0] other_limit;
	logic [2:0]  hdr_err;
	logic [2:0]  part;
	logic        hd, rl, hl;

	assign rec_dec     = rec_rem_q - 16'd1;
	assign hs_dec      = hs_rem_q - 24'd1;
	assign other_limit = {2'b00, max_len} + LEN_ALLOWANCE;

	// Header checks in priority order, on the length after the last header byte.
	always_comb begin
		hdr_err = ST_OK;
		if (major_q < MIN_MAJOR) begin
			hdr_err = ST_BAD_VERSION;
		end else if (!(type_q inside {CT_CCS, CT_ALERT, CT_HANDSHAKE, CT_APP_DATA})) begin
			hdr_err = ST_BAD_TYPE;
		end else if (type_q == CT_APP_DATA) begin
			if (length_d > {1'b0, max_len}) begin
				hdr_err = ST_TOO_LONG;
			end
		end else if ((minor_q != 8'd0) && ({1'b0, length_d} > other_limit)) begin
			hdr_err = ST_TOO_LONG;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		type_d    = type_q;
		major_d   = major_q;
		minor_d   = minor_q;
		length_d  = length_q;
		rec_rem_d = rec_rem_q;
		hs_cnt_d  = hs_cnt_q;
		hs_type_d = hs_type_q;
		hs_len_d  = hs_len_q;
		hs_rem_d  = hs_rem_q;
		err_d     = err_q;
		part      = phase_q;
		hd        = 1'b0;
		rl        = 1'b0;
		hl        = 1'b0;
		unique case (phase_q)
			PH_HDR: begin
				case (hdr_cnt_q)
					3'd0: type_d = data_byte;
					3'd1: major_d = data_byte;
					3'd2: minor_d = data_byte;
					3'd3: length_d = {data_byte, 8'd0};
					default: length_d = {length_q[15:8], data_byte};
				endcase
				if (hdr_cnt_q < 3'd4) begin
					hdr_cnt_d = hdr_cnt_q + 3'd1;
				end else begin
					hdr_cnt_d = 3'd0;
					if (hdr_err != ST_OK) begin
						err_d   = hdr_err;
						phase_d = PH_ERR;
					end else begin
						hd        = 1'b1;
						rec_rem_d = length_d;
						hs_cnt_d  = 2'd0;
						if (length_d == 16'd0) begin
							rl = 1'b1;
						end else if (type_q == CT_HANDSHAKE) begin
							phase_d = PH_HSH;
						end else begin
							phase_d = PH_PAY;
						end
					end
				end
			end
			PH_PAY: begin
				rec_rem_d = rec_dec;
				if (rec_dec == 16'd0) begin
					rl      = 1'b1;
					phase_d = PH_HDR;
				end
			end
			PH_HSH: begin
				rec_rem_d = rec_dec;
				case (hs_cnt_q)
					2'd0: hs_type_d = data_byte;
					2'd1: hs_len_d = {data_byte, 16'd0};
					2'd2: hs_len_d = {hs_len_q[23:16], data_byte, 8'd0};
					default: hs_len_d = {hs_len_q[23:8], data_byte};
				endcase
				if (hs_cnt_q != 2'd3) begin
					hs_cnt_d = hs_cnt_q + 2'd1;
					if (rec_dec == 16'd0) begin
						err_d   = ST_HS_OVERRUN;
						phase_d = PH_ERR;
					end
				end else begin
					hs_cnt_d = 2'd0;
					hs_rem_d = hs_len_d;
					if (hs_len_d > {8'd0, rec_dec}) begin
						err_d   = ST_HS_OVERRUN;
						phase_d = PH_ERR;
					end else if (hs_len_d == 24'd0) begin
						hl = 1'b1;
						if (rec_dec == 16'd0) begin
							rl      = 1'b1;
							phase_d = PH_HDR;
						end
					end else begin
						phase_d = PH_HSB;
					end
				end
			end
			PH_HSB: begin
				rec_rem_d = rec_dec;
				hs_rem_d  = hs_dec;
				if (hs_dec == 24'd0) begin
					hl = 1'b1;
					if (rec_dec == 16'd0) begin
						rl      = 1'b1;
						phase_d = PH_HDR;
					end else begin
						phase_d = PH_HSH;
					end
				end
			end
			default: begin
				part    = PH_ERR;
				phase_d = PH_ERR;
			end
		endcase
	end

	always_comb begin
		result.byte_out         = data_byte;
		result.byte_part        = part;
		result.content_type     = type_d;
		result.version_major    = major_d;
		result.version_minor    = minor_d;
		result.record_length    = length_d;
		result.handshake_type   = hs_type_d;
		result.handshake_length = hs_len_d;
		result.header_done      = hd;
		result.record_last      = rl;
		result.handshake_last   = hl;
		result.status           = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR;
			hdr_cnt_q <= 3'd0;
			type_q    <= 8'd0;
			major_q   <= 8'd0;
			minor_q   <= 8'd0;
			length_q  <= 16'd0;
			rec_rem_q <= 16'd0;
			hs_cnt_q  <= 2'd0;
			hs_type_q <= 8'd0;
			hs_len_q  <= 24'd0;
			hs_rem_q  <= 24'd0;
			err_q     <= ST_OK;
		end else if (fire) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			type_q    <= type_d;
			major_q   <= major_d;
			minor_q   <= minor_d;
			length_q  <= length_d;
			rec_rem_q <= rec_rem_d;
			hs_cnt_q  <= hs_cnt_d;
			hs_type_q <= hs_type_d;
			hs_len_q  <= hs_len_d;
			hs_rem_q  <= hs_rem_d;
			err_q     <= err_d;
		end
	end

endmodule
`default_nettype wire

FILE: sv/tlsd_queue.sv
// Short result queue between the parser and the output stage.
`default_nettype none
module tlsd_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  tlsd_pkg::result_t        push_data,
	input  wire logic                pop,
	output tlsd_pkg::result_t        pop_data,
	output tlsd_pkg::q_status_t      stat
);
	import tlsd_pkg::*;

	result_t           entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign pop_data   = entry_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/tlsd_out_stage.sv
// Back end: output register that drains the result queue.
`default_nettype none
module tlsd_out_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  tlsd_pkg::result_t   q_data,
	output logic                pop,
	output logic                result_valid,
	input  wire logic           result_ready,
	output tlsd_pkg::result_t   result
);
	import tlsd_pkg::*;

	logic    valid_q;
	result_t data_q;

	// Refill whenever the register is empty or being drained this cycle.
	assign pop          = !q_empty && (!valid_q || result_ready);
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_data;
		end
	end

endmodule
`default_nettype wire

FILE: sv/tls_record_deframer.sv
// Top level of the TLS record deframer: parser, result queue and output stage.
//
//  channel   handshake                   payload
//  -------   -------------------------   ---------------------------------------
//  config    cfg_wr_en                   cfg_wr_data (max_content_len)
//  input     data_valid / data_ready     data_byte
//  result    result_valid / result_ready byte_out ... status (one per byte)
//
// One byte per clock while data_ready is high: the parser updates its header state in the
// cycle of the transfer, so the per-byte state recurrence through the parser sets the rate.
// A result is written into the queue at its input transfer and then loaded into the output register.
// The 4-entry queue absorbs output stalls; data_ready drops only when it is full.
// Reset clears all parser state and the sticky error, and sets max_content_len to 16384.
`default_nettype none
`include "tls_record_deframer_defines.svh"
module tls_record_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [14:0] cfg_wr_data,
	input  wire logic        data_valid,
	output logic             data_ready,
	input  wire logic [7:0]  data_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [7:0]       byte_out,
	output logic [2:0]       byte_part,
	output logic [7:0]       content_type,
	output logic [7:0]       version_major,
	output logic [7:0]       version_minor,
	output logic [15:0]      record_length,
	output logic [7:0]       handshake_type,
	output logic [23:0]      handshake_length,
	output logic             header_done,
	output logic             record_last,
	output logic             handshake_last,
	output logic [2:0]       status
);
	import tlsd_pkg::*;

	logic [MAX_LEN_W-1:0] max_len_q;
	logic                 data_fire;
	logic                 pop;
	result_t              parsed;
	result_t              q_head;
	result_t              out_res;
	q_status_t            q_stat;

	// The limit register must be written only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// A transfer is taken whenever the queue has a free slot.
	assign data_ready = !q_stat.full;
	assign data_fire  = data_valid && data_ready;

	tlsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (data_fire),
		.data_byte (data_byte),
		.max_len   (max_len_q),
		.result    (parsed)
	);

	tlsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (data_fire),
		.push_data (parsed),
		.pop       (pop),
		.pop_data  (q_head),
		.stat      (q_stat)
	);

	tlsd_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_stat.empty),
		.q_data       (q_head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (out_res)
	);

	assign byte_out         = out_res.byte_out;
	assign byte_part        = out_res.byte_part;
	assign content_type     = out_res.content_type;
	assign version_major    = out_res.version_major;
	assign version_minor    = out_res.version_minor;
	assign record_length    = out_res.record_length;
	assign handshake_type   = out_res.handshake_type;
	assign handshake_length = out_res.handshake_length;
	assign header_done      = out_res.header_done;
	assign record_last      = out_res.record_last;
	assign handshake_last   = out_res.handshake_last;
	assign status           = out_res.status;

	// The queue never holds more than its depth, and never pops while empty.
	`TLSD_ASSERT_IMPLY(a_q_bound, clk, arst_n, 1'b1, q_stat.count <= QCNT_W'(QDEPTH))
	`TLSD_ASSERT_IMPLY(a_q_pop, clk, arst_n, pop, !q_stat.empty)
	// Once an error is reported, every later result carries the same status.
	`TLSD_ASSERT_NEXT(a_sticky, clk, arst_n, result_valid && status != ST_OK,
		!result_valid || status == $past(status))
	// A dropped byte only follows an error, and a good header never reports one.
	`TLSD_ASSERT_IMPLY(a_drop, clk, arst_n, result_valid && byte_part == PH_ERR,
		status != ST_OK && !header_done && !record_last && !handshake_last)
	`TLSD_ASSERT_IMPLY(a_hdr_ok, clk, arst_n, result_valid && header_done, status == ST_OK)

endmodule
`default_nettype wire
